// ----- hdl/timed_slot_ring_pool_top_defines.svh -----
// Assertion macros shared by the slot pool files.
`ifndef TIMED_SLOT_RING_POOL_TOP_DEFINES_SVH
`define TIMED_SLOT_RING_POOL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TSRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSRP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSRP_ASSERT(label, clk, rst_n, prop, msg)
`define TSRP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hdl/tsrp_pkg.sv -----
`timescale 1ns / 1ps
package tsrp_pkg;
  localparam int SLOTS = 64;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [2:0] ST_FREE = 3'd0;
  localparam logic [2:0] ST_RECYCLED = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_LIVE = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [34:0] NORM_MIN_SQ = 35'd268;
  localparam logic [12:0] OPAQUE = 13'd4096;
  // Slot payload as stored in the entry memory.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [23:0] extent;
    logic [23:0] init;
  } entry_t;
  localparam int EW = $bits(entry_t);
  // Classified command passed from front to back.
  typedef struct packed {
    logic tick;
    logic accept;
    logic [23:0] delta_t;
    entry_t ent;
  } cmd_t;
endpackage

// ----- hdl/tsrp_ram.sv -----
`timescale 1ns / 1ps
module tsrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/tsrp_front.sv -----
`timescale 1ns / 1ps
`include "timed_slot_ring_pool_top_defines.svh"
module tsrp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_op,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic [23:0]      in_extent,
  input  logic [23:0]      in_life,
  input  logic [23:0]      in_delta_t,
  output logic             q_valid,
  output tsrp_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);
  // Stage 1: capture and square; stage 2: sum and classify into a 2-entry queue.
  logic s1_v_r, s1_v_nxt;
  logic s1_op_r;
  logic [31:0] sqx_r, sqy_r, sqz_r;
  tsrp_pkg::entry_t s1_ent_r;
  logic [23:0] s1_dt_r;
  logic [1:0] cnt_r, cnt_nxt;
  tsrp_pkg::cmd_t q_r [2];
  logic [34:0] sum;
  tsrp_pkg::cmd_t cls;
  logic push;

  assign push = s1_v_r;
  assign busy = s1_v_r || (cnt_r != 2'd0);
  assign s1_v_nxt = start && !busy;
  assign sum = {3'd0, sqx_r} + {3'd0, sqy_r} + {3'd0, sqz_r};

  always_comb begin
    cls.tick = (s1_op_r == tsrp_pkg::OP_TICK);
    cls.accept = (sum > tsrp_pkg::NORM_MIN_SQ) && (s1_ent_r.extent != 24'd0)
                 && (s1_ent_r.init != 24'd0);
    cls.delta_t = s1_dt_r;
    cls.ent = s1_ent_r;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && cnt_r != 2'd0)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop && cnt_r != 2'd0) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      s1_v_r <= s1_v_nxt;
      cnt_r <= cnt_nxt;
    end
    if (s1_v_nxt) begin
      s1_op_r <= in_op;
      sqx_r <= 32'(in_norm_x) * 32'(in_norm_x);
      sqy_r <= 32'(in_norm_y) * 32'(in_norm_y);
      sqz_r <= 32'(in_norm_z) * 32'(in_norm_z);
      s1_ent_r <= '{px: in_pos_x, py: in_pos_y, pz: in_pos_z, nx: in_norm_x,
                    ny: in_norm_y, nz: in_norm_z, extent: in_extent, init: in_life};
      s1_dt_r <= in_delta_t;
    end
    if (q_pop && cnt_r == 2'd2) q_r[0] <= q_r[1];
    if (push) begin
      if (q_pop && cnt_r != 2'd0) q_r[1'(cnt_r - 2'd1)] <= cls;
      else q_r[cnt_r[0]] <= cls;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[0];

  `TSRP_ASSERT(a_no_overflow, clk, rst_n, cnt_r != 2'd3, "queue overflow")
  `TSRP_ASSERT(a_pop_valid, clk, rst_n, q_pop |-> q_valid, "pop on empty queue")
  `TSRP_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "busy not raised")
endmodule

// ----- hdl/tsrp_back.sv -----
`timescale 1ns / 1ps
`include "timed_slot_ring_pool_top_defines.svh"
module tsrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tsrp_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             idle,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [5:0]       out_slot,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [23:0]      out_extent,
  output logic [12:0]      out_opacity,
  output logic [6:0]       out_live_count,
  output logic             out_last
);
  localparam int SW = tsrp_pkg::SW;
  localparam int CW = tsrp_pkg::CW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_NONE = 3'd4;
  localparam logic [CW-1:0] FULL = CW'(tsrp_pkg::SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(tsrp_pkg::SLOTS - 1);

  logic [2:0] st_r, st_nxt;
  logic [tsrp_pkg::SLOTS-1:0] live_r;
  logic [SW-1:0] ring_r, idx_r;
  logic [CW-1:0] total_r, surv_r, emit_r;
  logic [23:0] dt_r;
  // Remaining time memory and entry memory, read one slot a cycle while the divider does not hold the walk.
  logic rem_we, ent_we;
  logic [SW-1:0] rem_wa, rd_a;
  logic [24:0] rem_wd, rem_rd;
  tsrp_pkg::entry_t ent_rd;
  logic rd_pend_r;
  logic [SW-1:0] rd_idx_r;
  // Divider: q = floor(rem*4096000/den), 14 quotient bits; bit 13 set means
  // the quotient is at least 8192 and the clamp applies.
  logic [4:0] dstep_r;
  logic [45:0] num_r;
  logic [30:0] den_r;
  logic [13:0] quo_r;
  logic [31:0] den100;
  tsrp_pkg::entry_t hold_r;
  logic [SW-1:0] hold_idx_r;

  always_comb begin
    out_valid = 1'b0; out_status = tsrp_pkg::ST_NONE; out_slot = '0;
    out_pos_x = '0; out_pos_y = '0; out_pos_z = '0;
    out_norm_x = '0; out_norm_y = '0; out_norm_z = '0;
    out_extent = '0; out_opacity = '0; out_live_count = 7'(total_r); out_last = 1'b1;
    q_pop = 1'b0; rem_we = 1'b0; ent_we = 1'b0; rem_wa = idx_r; rem_wd = '0;
    rd_a = idx_r; st_nxt = st_r;
    den100 = 32'(hold_r.init) * 32'd100;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_cmd.tick) begin
            out_valid = 1'b1;
            if (q_cmd.accept) begin
              rem_we = 1'b1; ent_we = 1'b1; rem_wa = ring_r;
              rem_wd = {1'b0, q_cmd.ent.init};
              out_status = live_r[ring_r] ? tsrp_pkg::ST_RECYCLED : tsrp_pkg::ST_FREE;
              out_slot = 6'(ring_r);
              out_pos_x = q_cmd.ent.px; out_pos_y = q_cmd.ent.py;
              out_pos_z = q_cmd.ent.pz; out_norm_x = q_cmd.ent.nx;
              out_norm_y = q_cmd.ent.ny; out_norm_z = q_cmd.ent.nz;
              out_extent = q_cmd.ent.extent; out_opacity = tsrp_pkg::OPAQUE;
              out_live_count = 7'((!live_r[ring_r] && total_r < FULL) ?
                                  total_r + 1'b1 : total_r);
            end else begin
              out_status = tsrp_pkg::ST_REJECT;
            end
          end else begin
            st_nxt = S_SCAN;
            rd_a = '0;
          end
        end
      end
      S_SCAN: begin
        // Pass one: age every live slot, one memory read per cycle.
        rd_a = idx_r + 1'b1;
        if (rd_pend_r && live_r[rd_idx_r] && rem_rd > {1'b0, dt_r}) begin
          rem_we = 1'b1; rem_wa = rd_idx_r; rem_wd = rem_rd - {1'b0, dt_r};
        end
        if (rd_pend_r && rd_idx_r == LAST_SLOT) begin
          st_nxt = (surv_r == '0 && !(live_r[rd_idx_r] && rem_rd > {1'b0, dt_r}))
                   ? S_NONE : S_EMIT;
          rd_a = '0;
        end
      end
      S_EMIT: begin
        // Pass two: fetch next live slot, then divide for its opacity.
        if (rd_pend_r && live_r[rd_idx_r]) st_nxt = S_DIV;
        else if (rd_pend_r && rd_idx_r == LAST_SLOT) st_nxt = S_IDLE;
        else rd_a = idx_r + 1'b1;
      end
      S_DIV: begin
        if (dstep_r == 5'd15) begin
          out_valid = 1'b1; out_status = tsrp_pkg::ST_LIVE;
          out_slot = 6'(hold_idx_r);
          out_pos_x = hold_r.px; out_pos_y = hold_r.py; out_pos_z = hold_r.pz;
          out_norm_x = hold_r.nx; out_norm_y = hold_r.ny; out_norm_z = hold_r.nz;
          out_extent = hold_r.extent;
          out_opacity = quo_r[13] || quo_r[12:0] > tsrp_pkg::OPAQUE ?
                        tsrp_pkg::OPAQUE : quo_r[12:0];
          out_last = (emit_r + 1'b1 == total_r);
          if (out_last) st_nxt = S_IDLE;
          else begin
            st_nxt = S_EMIT; rd_a = hold_idx_r + 1'b1;
          end
        end
      end
      S_NONE: begin
        out_valid = 1'b1; out_status = tsrp_pkg::ST_NONE; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign idle = (st_r == S_IDLE);

  tsrp_ram #(.WIDTH(25), .DEPTH(tsrp_pkg::SLOTS)) u_rem (
    .clk(clk), .we(rem_we), .waddr(rem_wa), .wdata(rem_wd), .raddr(rd_a), .rdata(rem_rd));
  tsrp_ram #(.WIDTH(tsrp_pkg::EW), .DEPTH(tsrp_pkg::SLOTS)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ring_r), .wdata(q_cmd.ent), .raddr(rd_a), .rdata(ent_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; live_r <= '0; ring_r <= '0; total_r <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_pend_r <= (st_nxt == S_SCAN) || (st_nxt == S_EMIT && st_nxt == st_r) ||
                   (st_nxt == S_EMIT && st_r != S_EMIT);
      if (st_r == S_IDLE && q_valid && !q_cmd.tick && q_cmd.accept) begin
        live_r[ring_r] <= 1'b1;
        ring_r <= (ring_r == LAST_SLOT) ? '0 : ring_r + 1'b1;
        if (!live_r[ring_r] && total_r < FULL) total_r <= total_r + 1'b1;
      end
      if (st_r == S_SCAN && rd_pend_r) begin
        if (live_r[rd_idx_r] && rem_rd <= {1'b0, dt_r}) live_r[rd_idx_r] <= 1'b0;
        if (rd_idx_r == LAST_SLOT)
          total_r <= surv_r + CW'(live_r[rd_idx_r] && rem_rd > {1'b0, dt_r});
      end
    end
    rd_idx_r <= rd_a;
    if (st_r == S_IDLE) begin
      idx_r <= '0; surv_r <= '0; emit_r <= '0; dt_r <= q_cmd.delta_t;
    end else if (st_r == S_SCAN) begin
      idx_r <= rd_a;
      if (rd_pend_r && live_r[rd_idx_r] && rem_rd > {1'b0, dt_r}) surv_r <= surv_r + 1'b1;
    end else if (st_r == S_EMIT) begin
      idx_r <= rd_a;
      if (st_nxt == S_DIV) begin
        hold_r <= ent_rd; hold_idx_r <= rd_idx_r;
        num_r <= 46'(rem_rd[23:0]) * 46'd4096000;
        dstep_r <= '0; quo_r <= '0;
      end
    end else if (st_r == S_DIV) begin
      if (dstep_r == 5'd0) begin
        den_r <= (den100 < 32'd65536) ? 31'd65536 : den100[30:0];
        dstep_r <= 5'd1;
      end else if (dstep_r < 5'd15) begin
        // Restoring division, one quotient bit per cycle, bit 13 down to bit 0.
        if ((num_r >> (5'd14 - dstep_r)) >= 46'(den_r)) begin
          num_r <= num_r - (46'(den_r) << (5'd14 - dstep_r));
          quo_r[4'(5'd14 - dstep_r)] <= 1'b1;
        end
        dstep_r <= dstep_r + 1'b1;
      end else begin
        emit_r <= emit_r + 1'b1;
        idx_r <= rd_a;
      end
    end
  end

  // A quotient of 8192 or more sets bit 13 at the first step, and the clamp
  // then gives full opacity whatever the lower bits hold.
  `TSRP_ASSERT(a_total_max, clk, rst_n, total_r <= FULL, "count above pool size")
  `TSRP_ASSERT(a_spawn_one, clk, rst_n,
    (st_r == S_IDLE && q_valid && !q_cmd.tick) |=> st_r == S_IDLE, "spawn took extra cycles")
  `TSRP_ASSERT(a_last_idle, clk, rst_n, (out_valid && out_last) |=> st_r == S_IDLE,
    "block kept working after final beat")
  `TSRP_ASSERT(a_live_total, clk, rst_n, (st_r == S_IDLE) |-> $countones(live_r) == total_r,
    "live flags disagree with count")
endmodule

// ----- hdl/timed_slot_ring_pool_top.sv -----
`timescale 1ns / 1ps
// Channel   Handshake         Payload
// input     start / busy      in_op, in_pos_*, in_norm_*, in_extent, in_life, in_delta_t
// result    out_valid strobe  out_status ... out_last, at most one beat per cycle
//
// A spawn beat is classified in the cycle after it is accepted; its single result
// beat is popped from the queue in the cycle after that, and then busy falls.
// A tick passes through the front and the queue, reads all 64 slots once,
// then walks the slots again; each survivor runs the serial opacity divider,
// whose final step carries its beat.
// Reset (rst_n low, synchronous) frees every slot and clears the ring pointer
// and the live count; entry memories are not cleared since data of free slots is never used.
// busy stays high while any item is in flight; the receiver cannot stall a beat.
module timed_slot_ring_pool_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_op,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic [23:0]      in_extent,
  input  logic [23:0]      in_life,
  input  logic [23:0]      in_delta_t,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [5:0]       out_slot,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [23:0]      out_extent,
  output logic [12:0]      out_opacity,
  output logic [6:0]       out_live_count,
  output logic             out_last
);
  // The front stage squares the normal and classifies each beat into a small queue.
  logic q_valid, q_pop, back_idle, front_busy;
  tsrp_pkg::cmd_t q_cmd;

  // The block is busy until the back end has finished the last queued command.
  assign busy = front_busy || !back_idle;

  // The front takes a beat only while the back end is idle, so it agrees with busy.
  tsrp_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start && back_idle), .busy(front_busy), .in_op(in_op),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_norm_z(in_norm_z),
    .in_extent(in_extent), .in_life(in_life), .in_delta_t(in_delta_t),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

  // The back end owns the slot memories and produces every result beat.
  tsrp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .idle(back_idle), .out_valid(out_valid), .out_status(out_status),
    .out_slot(out_slot), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_norm_x(out_norm_x), .out_norm_y(out_norm_y),
    .out_norm_z(out_norm_z), .out_extent(out_extent), .out_opacity(out_opacity),
    .out_live_count(out_live_count), .out_last(out_last));
endmodule
